FILE: hdl/ehct_pkg.sv
package ehct_pkg;

  // table geometry
  localparam int TBL_DEPTH = 16;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int CNT_W     = IDX_W + 1;

  // Q1.16 weight of one
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd32768;

  // accumulator width: full 17 x 32 product
  localparam int ACC_W = 49;

  // result status codes
  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_CAND     = 3'd3,
    ST_NONE     = 3'd4,
    ST_ABSENT   = 3'd5
  } status_t;

  // request commands
  typedef enum logic {
    CMD_STORE  = 1'b0,
    CMD_DECIDE = 1'b1
  } cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_MUL0,
    S_MUL1,
    S_WR,
    S_SORT,
    S_FIND,
    S_COUNT,
    S_EMIT,
    S_RES
  } state_t;

  // multiply-accumulate control
  typedef struct packed {
    logic en;
    logic clr;
  } mac_ctl_t;

endpackage

FILE: hdl/ehct_mac.sv
module ehct_mac (
  input  logic                        clk,
  input  ehct_pkg::mac_ctl_t          ctl,
  input  logic [16:0]                 opa,
  input  logic [31:0]                 opb,
  output logic [ehct_pkg::ACC_W-1:0]  acc
);
  import ehct_pkg::*;

  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [ACC_W-1:0] prod;

  // one 17 x 32 multiplier, accumulated over steps
  always_comb begin
    prod    = ACC_W'(opa) * ACC_W'(opb);
    acc_nxt = (ctl.clr ? '0 : acc_r) + prod;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: hdl/ewma_handover_candidate_table_core.sv
// Store: table scan, then on a hit a multiply-accumulate update of the slot.
// Decide: bubble sort of up to cnt passes, then find, count and emit scans;
//   results wait on output stalls.
// Throughput: one request at a time; in_stall stays high until the last
//   result is loaded into the output register. One shared multiplier.
// Reset: synchronous active-low rst_n empties the table and sets alpha to 0.5.
module ewma_handover_candidate_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_station_id,
  input  logic [15:0] in_frequency,
  input  logic [31:0] in_cir,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_station_id_out,
  output logic [15:0] out_frequency_out,
  output logic [2:0]  out_status,
  output logic        out_last
);
  import ehct_pkg::*;

  // table storage
  logic [15:0] ent_st_r  [TBL_DEPTH];
  logic [15:0] ent_fr_r  [TBL_DEPTH];
  logic [31:0] ent_avg_r [TBL_DEPTH];
  logic [CNT_W-1:0] cnt_r;

  logic [16:0] alpha_r;
  state_t state_r, state_nxt;

  // latched request
  logic        cmd_r;
  logic [15:0] st_r, fr_r;
  logic [31:0] cir_r;

  // sequencer registers
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic [31:0]      ref_r, ref_nxt;
  logic             swp_r, swp_nxt;
  status_t          res_st_r, res_st_nxt;
  logic [15:0]      res_fr_r, res_fr_nxt;

  // output register
  logic        ov_r;
  logic [15:0] o_st_r, o_fr_r;
  logic [2:0]  o_stat_r;
  logic        o_last_r;

  logic [IDX_W-1:0] ki, kp1;
  logic             can_load;
  logic [16:0]      a_sat;
  logic             sort_swap;
  logic             do_ins, do_upd, do_swap;
  logic             load_cand, load_res;

  mac_ctl_t          mctl;
  logic [16:0]       m_a;
  logic [31:0]       m_b;
  logic [ACC_W-1:0]  m_acc;

  assign ki       = k_r[IDX_W-1:0];
  assign kp1      = ki + IDX_W'(1);
  assign can_load = !ov_r || !out_stall;
  assign a_sat    = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign sort_swap = ent_avg_r[ki] < ent_avg_r[kp1];

  ehct_mac u_mac (
    .clk (clk),
    .ctl (mctl),
    .opa (m_a),
    .opb (m_b),
    .acc (m_acc)
  );

  // state register and sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    hit_r    <= hit_nxt;
    ref_r    <= ref_nxt;
    swp_r    <= swp_nxt;
    res_st_r <= res_st_nxt;
    res_fr_r <= res_fr_nxt;
  end

  // next state and controls
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    hit_nxt    = hit_r;
    ref_nxt    = ref_r;
    swp_nxt    = swp_r;
    res_st_nxt = res_st_r;
    res_fr_nxt = res_fr_r;
    mctl       = '0;
    m_a        = a_sat;
    m_b        = cir_r;
    do_ins     = 1'b0;
    do_upd     = 1'b0;
    do_swap    = 1'b0;
    load_cand  = 1'b0;
    load_res   = 1'b0;
    case (state_r)
      S_IDLE: begin
        k_nxt   = '0;
        swp_nxt = 1'b0;
        if (in_valid) begin
          if (in_cmd == CMD_STORE) begin
            state_nxt = S_SCAN;
          end else if (cnt_r < CNT_W'(2)) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_SORT;
          end
        end
      end
      S_SCAN: begin
        if (k_r < cnt_r) begin
          if (ent_st_r[ki] == st_r && ent_fr_r[ki] == fr_r) begin
            hit_nxt   = ki;
            state_nxt = S_MUL0;
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end else begin
          res_fr_nxt = fr_r;
          if (cnt_r == CNT_W'(TBL_DEPTH)) begin
            res_st_nxt = ST_FULL;
          end else begin
            do_ins     = 1'b1;
            res_st_nxt = ST_INSERTED;
          end
          state_nxt = S_RES;
        end
      end
      S_MUL0: begin
        mctl      = '{en: 1'b1, clr: 1'b1};
        m_a       = ALPHA_ONE - a_sat;
        m_b       = ent_avg_r[hit_r];
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        mctl      = '{en: 1'b1, clr: 1'b0};
        state_nxt = S_WR;
      end
      S_WR: begin
        do_upd     = 1'b1;
        res_st_nxt = ST_UPDATED;
        res_fr_nxt = fr_r;
        state_nxt  = S_RES;
      end
      S_SORT: begin
        // one compare-exchange of neighbors per cycle
        do_swap = sort_swap;
        if (k_r + CNT_W'(2) == cnt_r) begin
          k_nxt   = '0;
          swp_nxt = 1'b0;
          if (!(swp_r || sort_swap)) begin
            state_nxt = S_FIND;
          end
        end else begin
          k_nxt   = k_r + CNT_W'(1);
          swp_nxt = swp_r || sort_swap;
        end
      end
      S_FIND: begin
        if (k_r < cnt_r) begin
          if (ent_st_r[ki] == st_r) begin
            ref_nxt   = ent_avg_r[ki];
            k_nxt     = '0;
            n_nxt     = '0;
            state_nxt = S_COUNT;
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end else begin
          res_st_nxt = ST_ABSENT;
          res_fr_nxt = '0;
          state_nxt  = S_RES;
        end
      end
      S_COUNT: begin
        if (k_r < cnt_r) begin
          if (ent_avg_r[ki] > ref_r) begin
            n_nxt = n_r + CNT_W'(1);
          end
          k_nxt = k_r + CNT_W'(1);
        end else begin
          k_nxt = '0;
          if (n_r == '0) begin
            res_st_nxt = ST_NONE;
            res_fr_nxt = '0;
            state_nxt  = S_RES;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (ent_avg_r[ki] > ref_r) begin
          if (can_load) begin
            load_cand = 1'b1;
            n_nxt     = n_r - CNT_W'(1);
            k_nxt     = k_r + CNT_W'(1);
            if (n_r == CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          k_nxt = k_r + CNT_W'(1);
        end
      end
      S_RES: begin
        if (can_load) begin
          load_res  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // request capture and alpha register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      st_r  <= in_station_id;
      fr_r  <= in_frequency;
      cir_r <= in_cir;
    end
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha_r <= cfg_wdata;
    end
  end

  // table writes: insert, average update, sort exchange
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (do_ins) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (do_ins) begin
      ent_st_r[cnt_r[IDX_W-1:0]]  <= st_r;
      ent_fr_r[cnt_r[IDX_W-1:0]]  <= fr_r;
      ent_avg_r[cnt_r[IDX_W-1:0]] <= cir_r;
    end
    if (do_upd) begin
      ent_avg_r[hit_r] <= m_acc[47:16];
    end
    if (do_swap) begin
      ent_st_r[ki]   <= ent_st_r[kp1];
      ent_fr_r[ki]   <= ent_fr_r[kp1];
      ent_avg_r[ki]  <= ent_avg_r[kp1];
      ent_st_r[kp1]  <= ent_st_r[ki];
      ent_fr_r[kp1]  <= ent_fr_r[ki];
      ent_avg_r[kp1] <= ent_avg_r[ki];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_cand || load_res) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (load_cand) begin
      o_st_r   <= ent_st_r[ki];
      o_fr_r   <= ent_fr_r[ki];
      o_stat_r <= ST_CAND;
      o_last_r <= (n_r == CNT_W'(1));
    end else if (load_res) begin
      o_st_r   <= st_r;
      o_fr_r   <= res_fr_r;
      o_stat_r <= res_st_r;
      o_last_r <= 1'b1;
    end
  end

  assign out_valid          = ov_r;
  assign out_station_id_out = o_st_r;
  assign out_frequency_out  = o_fr_r;
  assign out_status         = o_stat_r;
  assign out_last           = o_last_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TBL_DEPTH))
    else $error("entry count above table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("entry count moved by other than one");

  a_emit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (n_r != '0))
    else $error("emit with no candidates left");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted without leaving idle");

  a_store_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT || state_r == S_COUNT) |-> (cmd_r == CMD_DECIDE))
    else $error("sort path entered on store request");
`endif

endmodule

FILE: test/ewma_handover_candidate_table_core_tb.sv
`timescale 1ns / 1ps

module ewma_handover_candidate_table_core_tb;
  import ehct_pkg::*;

  localparam int DEPTH = TBL_DEPTH;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] station;
    logic [15:0] freq;
    logic [31:0] cir;
  } req_t;

  typedef struct {
    logic [15:0] station;
    logic [15:0] freq;
    status_t     status;
    logic        last;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic [15:0] in_station_id = '0;
  logic [15:0] in_frequency = '0;
  logic [31:0] in_cir = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_station_id_out;
  logic [15:0] out_frequency_out;
  logic [2:0]  out_status;
  logic        out_last;

  ewma_handover_candidate_table_core dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_station_id(in_station_id), .in_frequency(in_frequency), .in_cir(in_cir),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_station_id_out(out_station_id_out), .out_frequency_out(out_frequency_out),
    .out_status(out_status), .out_last(out_last)
  );

  always #6 clk = ~clk;

  // shadow table and weight
  logic [16:0] alpha_q;
  int          tbl_cnt;
  logic [15:0] tbl_st [DEPTH];
  logic [15:0] tbl_fr [DEPTH];
  logic [31:0] tbl_avg[DEPTH];

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   errors = 0;
  bit   hold_long = 0;
  bit   pause_send = 0;

  // queue appends
  function automatic void add_req(req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic void add_exp(res_t r);
    expected_res.insert(expected_res.size(), r);
  endfunction

  function automatic res_t mk(logic [15:0] s, logic [15:0] f, status_t st, logic l);
    res_t r;
    r.station = s; r.freq = f; r.status = st; r.last = l;
    return r;
  endfunction

  // update shadow table and queue expected results for one accepted request
  task automatic predict_table(req_t q);
    logic [16:0] a;
    logic [48:0] acc;
    logic [15:0] ts, tf;
    logic [31:0] ta;
    int j, refi, n;
    bit hit;
    hit = 0;
    if (q.cmd == CMD_STORE) begin
      a = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
      for (int i = 0; i < tbl_cnt && !hit; i++) begin
        if (tbl_st[i] == q.station && tbl_fr[i] == q.freq) begin
          acc = 49'(ALPHA_ONE - a) * 49'(tbl_avg[i]) + 49'(a) * 49'(q.cir);
          tbl_avg[i] = acc[47:16];
          hit = 1;
        end
      end
      if (hit) add_exp(mk(q.station, q.freq, ST_UPDATED, 1'b1));
      else if (tbl_cnt >= DEPTH)
        add_exp(mk(q.station, q.freq, ST_FULL, 1'b1));
      else begin
        tbl_st[tbl_cnt] = q.station; tbl_fr[tbl_cnt] = q.freq;
        tbl_avg[tbl_cnt] = q.cir; tbl_cnt++;
        add_exp(mk(q.station, q.freq, ST_INSERTED, 1'b1));
      end
    end else begin
      // stable sort, highest average first
      for (int i = 1; i < tbl_cnt; i++) begin
        ts = tbl_st[i]; tf = tbl_fr[i]; ta = tbl_avg[i]; j = i;
        while (j > 0 && tbl_avg[j-1] < ta) begin
          tbl_st[j] = tbl_st[j-1]; tbl_fr[j] = tbl_fr[j-1]; tbl_avg[j] = tbl_avg[j-1];
          j--;
        end
        tbl_st[j] = ts; tbl_fr[j] = tf; tbl_avg[j] = ta;
      end
      refi = -1;
      for (int i = 0; i < tbl_cnt && refi < 0; i++)
        if (tbl_st[i] == q.station) refi = i;
      if (refi < 0) add_exp(mk(q.station, 16'd0, ST_ABSENT, 1'b1));
      else begin
        n = 0;
        for (int i = 0; i < tbl_cnt; i++)
          if (tbl_avg[i] > tbl_avg[refi]) begin
            add_exp(mk(tbl_st[i], tbl_fr[i], ST_CAND, 1'b0));
            n++;
          end
        if (n == 0) add_exp(mk(q.station, 16'd0, ST_NONE, 1'b1));
        else expected_res[$].last = 1'b1;
      end
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // request driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_table('{cmd_t'(in_cmd), in_station_id,
                                                  in_frequency, in_cir});
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || pause_send || pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          req_t q;
          q = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_cmd <= q.cmd; in_station_id <= q.station;
          in_frequency <= q.freq; in_cir <= q.cir;
          send_gap <= ($urandom_range(0, 3) == 0) ? 0 : gap_len();
        end
      end
    end
  end

  // result monitor and receiver stall
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_res.size() == 0) begin
          $display("%0t unexpected result: act st=%h fr=%h status=%0d last=%b", $time,
                   out_station_id_out, out_frequency_out, out_status, out_last);
          errors++;
        end else begin
          res_t e;
          e = expected_res.pop_front();
          if (e.station !== out_station_id_out || e.freq !== out_frequency_out ||
              e.status !== out_status || e.last !== out_last) begin
            $display("%0t mismatch: exp st=%h fr=%h status=%0d last=%b", $time,
                     e.station, e.freq, e.status, e.last);
            $display("%0t           act st=%h fr=%h status=%0d last=%b", $time,
                     out_station_id_out, out_frequency_out, out_status, out_last);
            errors++;
          end
        end
      end
      if (hold_long) out_stall <= 1'b1;
      else if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        recv_gap <= gap_len();
      end else out_stall <= 1'b0;
    end
  end

  // long receiver hold-off counted in cycles, while a large batch is pending
  initial begin
    wait (rst_n);
    wait (pending_reqs.size() > 40);
    hold_long = 1'b1;
    repeat (300) @(posedge clk);
    hold_long = 1'b0;
  end

  function automatic req_t rq(cmd_t c, logic [15:0] s, logic [15:0] f, logic [31:0] v);
    req_t q;
    q.cmd = c; q.station = s; q.freq = f; q.cir = v;
    return q;
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_res.size() == 0 && !in_valid);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_alpha(logic [16:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    alpha_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random phase: a small station pool so hits, fills and candidates happen
  task automatic random_phase(int n);
    logic [15:0] s;
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      if ($urandom_range(0, 4) == 0) add_req(rq(CMD_DECIDE, s,
                                       16'($urandom), 32'($urandom)));
      else add_req(rq(CMD_STORE, s,
             ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2)),
             ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom)));
    end
  endtask

  initial begin
    alpha_q = ALPHA_RESET;
    tbl_cnt = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty decide, inserts, ties, hit, full table
    add_req(rq(CMD_DECIDE, 16'h0005, 16'hFFFF, 32'hFFFF_FFFF));
    add_req(rq(CMD_STORE, 16'h0001, 16'h0000, 32'h0001_0000));
    add_req(rq(CMD_STORE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    add_req(rq(CMD_STORE, 16'h0002, 16'h0001, 32'h0001_0000));
    add_req(rq(CMD_STORE, 16'h0001, 16'h0007, 32'h0000_0000));
    add_req(rq(CMD_STORE, 16'h0001, 16'h0000, 32'h0003_0000));
    add_req(rq(CMD_DECIDE, 16'h0001, 16'h0000, 32'h0));
    add_req(rq(CMD_DECIDE, 16'hFFFF, 16'h0000, 32'h0));
    add_req(rq(CMD_DECIDE, 16'h0009, 16'h0000, 32'h0));
    for (int i = 0; i < 13; i++)
      add_req(rq(CMD_STORE, 16'h0100 + 16'(i), 16'(i), 32'($urandom)));
    add_req(rq(CMD_DECIDE, 16'h0001, 16'h0000, 32'h0));
    drain();
    // sender pause until everything is back, then weight extremes
    write_alpha(17'd0);
    add_req(rq(CMD_STORE, 16'hFFFF, 16'hFFFF, 32'h0));
    add_req(rq(CMD_STORE, 16'h0001, 16'h0000, 32'h1234_5678));
    drain();
    write_alpha(17'h1FFFF);
    add_req(rq(CMD_STORE, 16'h0001, 16'h0000, 32'h8000_0001));
    add_req(rq(CMD_DECIDE, 16'h0002, 16'h0000, 32'h0));
    drain();
    // fresh table is not possible without reset, so random phases run on it
    write_alpha(ALPHA_ONE);
    random_phase(60);
    drain();
    pause_send = 1'b1;
    random_phase(40);
    repeat (50) @(posedge clk);
    pause_send = 1'b0;
    drain();
    write_alpha(17'($urandom_range(0, 65536)));
    random_phase(110);
    drain();
    write_alpha(17'd1);
    random_phase(100);
    drain();
    if (errors == 0 && expected_res.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #30ms;
    $display("status: fail");
    $finish;
  end

endmodule
